[sv/hc_pkg.sv]
// Package for the 2x2 Hill cipher block: constants, register indexes,
// controller states, command struct and modulo-alphabet arithmetic helpers.
// No dependencies.
package hc_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int LW            = 5;
  localparam int PROD_W        = 2 * LW;
  localparam int SUM_W         = PROD_W + 1;
  localparam int MOD_RECIP     = 2521;
  localparam int MOD_SHIFT     = 16;
  localparam int MOD_Q_W       = 7;
  localparam int RECIP_PROD_W  = SUM_W + 12;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;

  localparam logic [LW-1:0]    PAD_LETTER = LW'(23 % ALPHABET_SIZE);
  localparam logic [SUM_W-1:0] DET_BIAS   = SUM_W'(ALPHABET_SIZE * ALPHABET_SIZE);

  typedef enum logic [2:0] {
    REG_KEY_A = 3'd0,
    REG_KEY_B = 3'd1,
    REG_KEY_C = 3'd2,
    REG_KEY_D = 3'd3,
    REG_MODE  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [LW-1:0] a;
    logic [LW-1:0] b;
    logic [LW-1:0] c;
    logic [LW-1:0] d;
    logic          decrypt;
  } key_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DET_MUL,
    ST_DET_RED,
    ST_COEF_MUL,
    ST_COEF_RED,
    ST_PAIR_MUL,
    ST_PAIR_RED,
    ST_OUT0,
    ST_OUT1
  } state_t;

  typedef struct packed {
    logic hold_first;
    logic load_pair;
    logic load_pad;
    logic det_mul;
    logic det_red;
    logic coef_mul;
    logic coef_red;
    logic pair_mul;
    logic pair_red;
    logic sel_second;
  } dp_cmd_t;

  function automatic logic [LW-1:0] reduce_letter(input logic [LW-1:0] v);
    logic [LW-1:0] r;
    r = (v >= LW'(ALPHABET_SIZE)) ? v - LW'(ALPHABET_SIZE) : v;
    return r;
  endfunction

  function automatic logic [LW-1:0] mod_alpha(input logic [SUM_W-1:0] v);
    logic [RECIP_PROD_W-1:0] prod;
    logic [MOD_Q_W-1:0]      q;
    logic [SUM_W-1:0]        r;
    prod = RECIP_PROD_W'(v) * RECIP_PROD_W'(MOD_RECIP);
    q    = prod[MOD_SHIFT +: MOD_Q_W];
    r    = v - SUM_W'(q) * SUM_W'(ALPHABET_SIZE);
    return r[LW-1:0];
  endfunction

  // Returns {valid, inverse}; inverse is zero when none exists.
  function automatic logic [LW:0] inv_lookup(input logic [LW-1:0] v);
    logic [LW:0] r;
    case (v)
      5'd1:    r = {1'b1, 5'd1};
      5'd3:    r = {1'b1, 5'd9};
      5'd5:    r = {1'b1, 5'd21};
      5'd7:    r = {1'b1, 5'd15};
      5'd9:    r = {1'b1, 5'd3};
      5'd11:   r = {1'b1, 5'd19};
      5'd15:   r = {1'b1, 5'd7};
      5'd17:   r = {1'b1, 5'd23};
      5'd19:   r = {1'b1, 5'd11};
      5'd21:   r = {1'b1, 5'd5};
      5'd23:   r = {1'b1, 5'd17};
      5'd25:   r = {1'b1, 5'd25};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[sv/hc_regs.sv]
// Configuration register file of the Hill cipher block on an APB-style port.
// Depends on hc_pkg.
module hc_regs import hc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output key_cfg_t          key_cfg
);

  key_cfg_t key_r, key_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    key_nxt = key_r;
    if (wr_en) begin
      case (idx)
        REG_KEY_A: key_nxt.a = pwdata[LW-1:0];
        REG_KEY_B: key_nxt.b = pwdata[LW-1:0];
        REG_KEY_C: key_nxt.c = pwdata[LW-1:0];
        REG_KEY_D: key_nxt.d = pwdata[LW-1:0];
        REG_MODE:  key_nxt.decrypt = pwdata[0];
        default:   key_nxt = key_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KEY_A: prdata = DATA_W'(key_r.a);
      REG_KEY_B: prdata = DATA_W'(key_r.b);
      REG_KEY_C: prdata = DATA_W'(key_r.c);
      REG_KEY_D: prdata = DATA_W'(key_r.d);
      REG_MODE:  prdata = DATA_W'(key_r.decrypt);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '{a: LW'(1), b: '0, c: '0, d: LW'(1), decrypt: 1'b0};
    end else begin
      key_r <= key_nxt;
    end
  end

  assign key_cfg = key_r;

endmodule

[sv/hc_ctrl.sv]
// Controller state machine of the Hill cipher block: pairs letters and
// sequences the datapath steps and the two result transactions. Depends on hc_pkg.
module hc_ctrl import hc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    in_message_end,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   holding_r, holding_nxt;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt   = state_r;
    holding_nxt = holding_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (holding_r) begin
            holding_nxt = 1'b0;
            state_nxt   = ST_DET_MUL;
          end else if (in_message_end) begin
            state_nxt = ST_DET_MUL;
          end else begin
            holding_nxt = 1'b1;
          end
        end
      end
      ST_DET_MUL:  state_nxt = ST_DET_RED;
      ST_DET_RED:  state_nxt = ST_COEF_MUL;
      ST_COEF_MUL: state_nxt = ST_COEF_RED;
      ST_COEF_RED: state_nxt = ST_PAIR_MUL;
      ST_PAIR_MUL: state_nxt = ST_PAIR_RED;
      ST_PAIR_RED: state_nxt = ST_OUT0;
      ST_OUT0: begin
        if (out_ready) begin
          state_nxt = ST_OUT1;
        end
      end
      ST_OUT1: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_pair  = in_valid && holding_r;
        cmd.load_pad   = in_valid && !holding_r && in_message_end;
        cmd.hold_first = in_valid && !holding_r && !in_message_end;
      end
      ST_DET_MUL:  cmd.det_mul  = 1'b1;
      ST_DET_RED:  cmd.det_red  = 1'b1;
      ST_COEF_MUL: cmd.coef_mul = 1'b1;
      ST_COEF_RED: cmd.coef_red = 1'b1;
      ST_PAIR_MUL: cmd.pair_mul = 1'b1;
      ST_PAIR_RED: cmd.pair_red = 1'b1;
      ST_OUT0:     out_valid    = 1'b1;
      ST_OUT1: begin
        out_valid      = 1'b1;
        cmd.sel_second = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      holding_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      holding_r <= holding_nxt;
    end
  end

endmodule

[sv/hc_dp.sv]
// Datapath of the Hill cipher block: pair registers, four shared 5x5
// multipliers, modulo reduction and result registers. Depends on hc_pkg.
module hc_dp import hc_pkg::*; (
  input  logic          clk,
  input  key_cfg_t      key_cfg,
  input  dp_cmd_t       cmd,
  input  logic [LW-1:0] in_letter_in,
  input  logic          in_message_end,
  output logic [LW-1:0] out_letter_out,
  output logic          out_message_last,
  output logic          out_key_error
);

  logic [LW-1:0]     held_r, p0_r, p1_r, det_r, y0_r, y1_r;
  logic              last_r, err_r;
  logic [PROD_W-1:0] prod_r [4];
  logic [PROD_W-1:0] prod_nxt [4];
  logic [LW-1:0]     m_r [4];
  logic [LW-1:0]     opx [4];
  logic [LW-1:0]     opy [4];
  logic [LW-1:0]     ka, kb, kc, kd, nb, nc, letter, inv;
  logic [LW:0]       inv_res;

  assign letter  = reduce_letter(in_letter_in);
  assign ka      = reduce_letter(key_cfg.a);
  assign kb      = reduce_letter(key_cfg.b);
  assign kc      = reduce_letter(key_cfg.c);
  assign kd      = reduce_letter(key_cfg.d);
  assign nb      = (kb == '0) ? '0 : LW'(ALPHABET_SIZE) - kb;
  assign nc      = (kc == '0) ? '0 : LW'(ALPHABET_SIZE) - kc;
  assign inv_res = inv_lookup(det_r);
  assign inv     = inv_res[LW-1:0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      opx[i] = '0;
      opy[i] = '0;
    end
    if (cmd.det_mul) begin
      opx[0] = ka; opy[0] = kd;
      opx[1] = kb; opy[1] = kc;
    end else if (cmd.coef_mul) begin
      if (key_cfg.decrypt) begin
        opx[0] = kd; opx[1] = nb; opx[2] = nc; opx[3] = ka;
        for (int i = 0; i < 4; i++) opy[i] = inv;
      end else begin
        opx[0] = ka; opx[1] = kb; opx[2] = kc; opx[3] = kd;
        for (int i = 0; i < 4; i++) opy[i] = LW'(1);
      end
    end else if (cmd.pair_mul) begin
      opx[0] = m_r[0]; opy[0] = p0_r;
      opx[1] = m_r[1]; opy[1] = p1_r;
      opx[2] = m_r[2]; opy[2] = p0_r;
      opx[3] = m_r[3]; opy[3] = p1_r;
    end
    for (int i = 0; i < 4; i++) begin
      prod_nxt[i] = PROD_W'(opx[i]) * PROD_W'(opy[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_first) begin
      held_r <= letter;
    end
    if (cmd.load_pair) begin
      p0_r   <= held_r;
      p1_r   <= letter;
      last_r <= in_message_end;
    end
    if (cmd.load_pad) begin
      p0_r   <= letter;
      p1_r   <= PAD_LETTER;
      last_r <= 1'b1;
    end
    if (cmd.det_mul || cmd.coef_mul || cmd.pair_mul) begin
      for (int i = 0; i < 4; i++) prod_r[i] <= prod_nxt[i];
    end
    if (cmd.det_red) begin
      det_r <= mod_alpha(SUM_W'(prod_r[0]) + DET_BIAS - SUM_W'(prod_r[1]));
    end
    if (cmd.coef_mul) begin
      err_r <= key_cfg.decrypt && !inv_res[LW];
    end
    if (cmd.coef_red) begin
      for (int i = 0; i < 4; i++) m_r[i] <= mod_alpha(SUM_W'(prod_r[i]));
    end
    if (cmd.pair_red) begin
      y0_r <= mod_alpha(SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]));
      y1_r <= mod_alpha(SUM_W'(prod_r[2]) + SUM_W'(prod_r[3]));
    end
  end

  assign out_letter_out   = cmd.sel_second ? y1_r : y0_r;
  assign out_message_last = cmd.sel_second && last_r;
  assign out_key_error    = err_r;

endmodule

[sv/hill_cipher_2x2_mod26.sv]
// 2x2 Hill cipher over 26 letters. A letter that opens a pair is taken and held.
// A letter that closes a pair, or a lone final letter padded with X, starts a
// sequence of six compute steps on four shared 5x5 multipliers (determinant,
// key coefficients, inverted when decrypting, and pair product, each followed
// by a modulo reduction), after which the two result letters are offered one
// after the other, each held while the result side stalls; in_ready is high
// only while no pair is in work.
// Depends on hc_pkg, hc_regs, hc_ctrl and hc_dp.
module hill_cipher_2x2_mod26 import hc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [LW-1:0]     in_letter_in,
  input  logic              in_message_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [LW-1:0]     out_letter_out,
  output logic              out_message_last,
  output logic              out_key_error,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  key_cfg_t key_cfg;
  dp_cmd_t  cmd;

  hc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key_cfg (key_cfg)
  );

  hc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_message_end (in_message_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cmd            (cmd)
  );

  hc_dp u_dp (
    .clk              (clk),
    .key_cfg          (key_cfg),
    .cmd              (cmd),
    .in_letter_in     (in_letter_in),
    .in_message_end   (in_message_end),
    .out_letter_out   (out_letter_out),
    .out_message_last (out_message_last),
    .out_key_error    (out_key_error)
  );

endmodule

[sv/hc_checker.sv]
// Port-level checker for the Hill cipher block, bound to the top level.
// Depends on hc_pkg.
module hc_checker import hc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [LW-1:0]     out_letter_out,
  input logic              out_message_last,
  input logic              out_key_error
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("Input taken while a result transaction is pending.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_letter_out)
      && $stable(out_message_last) && $stable(out_key_error))
    else $error("Stalled result transaction changed.");

  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_letter_out < LW'(ALPHABET_SIZE))
    else $error("Result letter out of range.");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_error |-> out_letter_out == '0)
    else $error("Key error with a nonzero letter.");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_message_last |=> in_ready && !out_valid)
    else $error("Block not idle after the final letter of a message.");

endmodule

bind hill_cipher_2x2_mod26 hc_checker u_hc_checker (.*);

[tb/sv/hill_cipher_2x2_mod26_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the 2x2 Hill cipher block: directed and random messages
// of letters under several key settings, checked in order by a scoreboard with its own model.
// Depends on hc_pkg and hill_cipher_2x2_mod26.
module hill_cipher_2x2_mod26_tb;
  import hc_pkg::*;

  typedef struct packed {
    logic [LW-1:0] letter;
    logic          last;
    logic          key_err;
  } letter_res_t;

  class hill_letter_checker;
    key_cfg_t      cfg;
    logic [LW-1:0] held_letter;
    bit            holding;
    letter_res_t   expected_letters[$];
    int            mismatches;

    function new();
      cfg         = '{a: 5'd1, b: 5'd0, c: 5'd0, d: 5'd1, decrypt: 1'b0};
      held_letter = '0;
      holding     = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [LW-1:0] v);
      case (idx)
        REG_KEY_A: cfg.a = v;
        REG_KEY_B: cfg.b = v;
        REG_KEY_C: cfg.c = v;
        REG_KEY_D: cfg.d = v;
        REG_MODE:  cfg.decrypt = v[0];
        default: ;
      endcase
    endfunction

    function void push_pair(int r0, int r1, bit last, bit err);
      expected_letters.push_back(letter_res_t'{LW'(r0), 1'b0, err});
      expected_letters.push_back(letter_res_t'{LW'(r1), last, err});
    endfunction

    function void cipher_pair(int p0, int p1, bit last);
      int a, b, c, d, det, inv;
      int m00, m01, m10, m11;
      a = int'(cfg.a) % ALPHABET_SIZE;
      b = int'(cfg.b) % ALPHABET_SIZE;
      c = int'(cfg.c) % ALPHABET_SIZE;
      d = int'(cfg.d) % ALPHABET_SIZE;
      if (cfg.decrypt) begin
        det = (a * d + ALPHABET_SIZE - (b * c) % ALPHABET_SIZE) % ALPHABET_SIZE;
        inv = 0;
        for (int x = 1; x < ALPHABET_SIZE; x++) begin
          if (inv == 0 && (det * x) % ALPHABET_SIZE == 1) inv = x;
        end
        if (inv == 0) begin
          push_pair(0, 0, last, 1'b1);
          return;
        end
        m00 = (d * inv) % ALPHABET_SIZE;
        m01 = (((ALPHABET_SIZE - b) % ALPHABET_SIZE) * inv) % ALPHABET_SIZE;
        m10 = (((ALPHABET_SIZE - c) % ALPHABET_SIZE) * inv) % ALPHABET_SIZE;
        m11 = (a * inv) % ALPHABET_SIZE;
      end else begin
        m00 = a;
        m01 = b;
        m10 = c;
        m11 = d;
      end
      push_pair((m00 * p0 + m01 * p1) % ALPHABET_SIZE,
                (m10 * p0 + m11 * p1) % ALPHABET_SIZE, last, 1'b0);
    endfunction

    function void note_letter(logic [LW-1:0] letter_in, logic msg_end);
      int l;
      l = int'(letter_in) % ALPHABET_SIZE;
      if (holding) begin
        holding = 1'b0;
        cipher_pair(int'(held_letter), l, msg_end);
      end else if (msg_end) begin
        cipher_pair(l, int'(PAD_LETTER), 1'b1);
      end else begin
        held_letter = LW'(l);
        holding     = 1'b1;
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_letter(logic [LW-1:0] letter, logic last, logic err);
      letter_res_t want;
      if (expected_letters.size() == 0) begin
        flag($sformatf("Unexpected result transaction: letter=%0d last=%0b key_error=%0b",
                       letter, last, err));
        return;
      end
      want = expected_letters.pop_front();
      if (want.letter !== letter || want.last !== last || want.key_err !== err)
        flag($sformatf({"Mismatch: expected letter=%0d last=%0b key_error=%0b, ",
                        "got letter=%0d last=%0b key_error=%0b"},
                       want.letter, want.last, want.key_err, letter, last, err));
    endfunction

    function int pending();
      return expected_letters.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [LW-1:0]     in_letter_in = '0;
  logic              in_message_end = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [LW-1:0]     out_letter_out;
  logic              out_message_last;
  logic              out_key_error;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  hill_letter_checker checker_sb = new();
  bit                 no_idle = 1'b0;
  int                 msg_left = 0;

  hill_cipher_2x2_mod26 dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_letter_in     (in_letter_in),
    .in_message_end   (in_message_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_letter_out   (out_letter_out),
    .out_message_last (out_message_last),
    .out_key_error    (out_key_error),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    if (rst_n) out_ready <= no_idle || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      checker_sb.check_letter(out_letter_out, out_message_last, out_key_error);
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    checker_sb.set_reg(idx, value[LW-1:0]);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_key(int a, int b, int c, int d, bit decrypt);
    reg_write(REG_KEY_A, DATA_W'(a));
    reg_write(REG_KEY_B, DATA_W'(b));
    reg_write(REG_KEY_C, DATA_W'(c));
    reg_write(REG_KEY_D, DATA_W'(d));
    reg_write(REG_MODE, DATA_W'(decrypt));
  endtask

  task automatic send_letter(logic [LW-1:0] letter, logic msg_end);
    int gap;
    @(negedge clk);
    if (!no_idle && $urandom_range(99) < 20) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_letter_in   = letter;
    in_message_end = msg_end;
    do @(posedge clk); while (!in_ready);
    checker_sb.note_letter(letter, msg_end);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (checker_sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_random_letter();
    logic [LW-1:0] letter;
    logic          msg_end;
    if (msg_left == 0) msg_left = $urandom_range(1, 9);
    msg_left--;
    msg_end = (msg_left == 0);
    if ($urandom_range(99) < 10) msg_end = 1'($urandom_range(1));
    if (msg_end) msg_left = 0;
    letter = ($urandom_range(99) < 85) ? LW'($urandom_range(25)) : LW'($urandom_range(31));
    send_letter(letter, msg_end);
  endtask

  function automatic int random_key();
    return ($urandom_range(99) < 85) ? $urandom_range(25) : $urandom_range(31, 26);
  endfunction

  task automatic run_directed();
    send_letter(5'd0, 1'b0);
    send_letter(5'd25, 1'b0);
    send_letter(5'd31, 1'b0);
    send_letter(5'd26, 1'b1);
    send_letter(5'd7, 1'b1);
    send_letter(5'd25, 1'b1);
    send_letter(5'd13, 1'b0);
    send_letter(5'd0, 1'b1);
    drop_valid();
  endtask

  initial begin
    int errors;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    drain();
    set_key(3, 3, 2, 5, 1'b0);
    run_directed();
    drain();
    set_key(3, 3, 2, 5, 1'b1);
    run_directed();
    drain();
    set_key(2, 4, 6, 8, 1'b1);
    run_directed();
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: set_key(0, 0, 0, 0, 1'b0);
        1: set_key(25, 25, 25, 25, 1'b1);
        2: set_key(31, 31, 31, 31, 1'b0);
        3: set_key(25, 0, 0, 25, 1'b1);
        default: set_key(random_key(), random_key(), random_key(), random_key(),
                         1'($urandom_range(1)));
      endcase
      no_idle = (phase == 4);
      for (int n = 0; n < 115; n++) begin
        if (phase == 6 && n == 57) begin
          drop_valid();
          while (checker_sb.pending() != 0) @(posedge clk);
        end
        send_random_letter();
      end
      drop_valid();
      no_idle = 1'b0;
      drain();
    end

    errors = checker_sb.mismatches + checker_sb.pending();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[hill_cipher_2x2_mod26.f]
sv/hc_pkg.sv
sv/hc_regs.sv
sv/hc_ctrl.sv
sv/hc_dp.sv
sv/hill_cipher_2x2_mod26.sv
sv/hc_checker.sv
tb/sv/hill_cipher_2x2_mod26_tb.sv
